>>> rtl/system_tick_down_timer_top_macros.svh
// ----------------------------------------------------------------------------
// System tick down-timer assertion macros
// Concurrent assertion forms used by the timer core.
// ----------------------------------------------------------------------------
`ifndef SYSTEM_TICK_DOWN_TIMER_TOP_MACROS_SVH
`define SYSTEM_TICK_DOWN_TIMER_TOP_MACROS_SVH

// Checked on every clock edge outside reset.
`define SYSTICK_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every clock edge, during reset too.
`define SYSTICK_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

>>> rtl/systick_pkg.sv
// ----------------------------------------------------------------------------
// System tick down-timer package
// Operation codes, register selects, control bit positions and item types.
// ----------------------------------------------------------------------------
package systick_pkg;

  typedef enum logic [1:0] {
    FUNC_TICK  = 2'd0,
    FUNC_READ  = 2'd1,
    FUNC_WRITE = 2'd2
  } func_e;

  typedef enum logic [1:0] {
    SEL_CTRL    = 2'd0,
    SEL_RELOAD  = 2'd1,
    SEL_CURRENT = 2'd2
  } sel_e;

  localparam int unsigned CtrlRunBit    = 0;
  localparam int unsigned CtrlIrqBit    = 1;
  localparam int unsigned CtrlClkSrcBit = 2;
  localparam int unsigned CtrlSingleBit = 3;
  localparam int unsigned CtrlFlagBit   = 16;

  localparam int unsigned DataWidth = 32;
  localparam int unsigned PrescWidth = 3;

  typedef struct packed {
    logic [1:0]           func;
    logic [1:0]           reg_select;
    logic [DataWidth-1:0] write_data;
  } item_t;

  typedef struct packed {
    logic [DataWidth-1:0] read_data;
    logic                 interrupt_pulse;
    logic                 reached_zero;
  } result_t;

endpackage

>>> rtl/systick_in_reg.sv
// ----------------------------------------------------------------------------
// System tick down-timer input register
// Holds one accepted request until the core consumes it.
// ----------------------------------------------------------------------------
module systick_in_reg (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_valid_i,
  output logic                s_ready_o,
  input  systick_pkg::item_t  s_item_i,
  input  logic                consume_i,
  output logic                valid_o,
  output systick_pkg::item_t  item_o
);

  logic               valid_q, valid_d;
  systick_pkg::item_t item_q;
  logic               s_fire;

  assign s_ready_o = !valid_q || consume_i;
  assign s_fire    = s_valid_i && s_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (s_fire) begin
      valid_d = 1'b1;
    end else if (consume_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      item_q <= s_item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

>>> rtl/systick_core.sv
// ----------------------------------------------------------------------------
// System tick down-timer core
// Timer state and the single-pass logic that applies one request to it.
// ----------------------------------------------------------------------------
`include "system_tick_down_timer_top_macros.svh"

module systick_core #(
  parameter int unsigned COUNTER_WIDTH = 24
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic                 cfg_wdata_i,
  input  logic                 fire_i,
  input  systick_pkg::item_t   item_i,
  output systick_pkg::result_t res_o
);

  logic                                 use_core_q;
  logic                                 run_q, run_d;
  logic                                 irq_en_q, irq_en_d;
  logic                                 single_q, single_d;
  logic                                 flag_q, flag_d;
  logic [COUNTER_WIDTH-1:0]             reload_q, reload_d;
  logic [COUNTER_WIDTH-1:0]             cur_q, cur_d;
  logic [systick_pkg::PrescWidth-1:0]   presc_q, presc_d;
  logic [COUNTER_WIDTH-1:0]             dec;
  logic                                 count_event;
  logic [systick_pkg::DataWidth-1:0]    ctrl_word;

  always_comb begin
    ctrl_word = '0;
    ctrl_word[systick_pkg::CtrlRunBit]    = run_q;
    ctrl_word[systick_pkg::CtrlIrqBit]    = irq_en_q;
    ctrl_word[systick_pkg::CtrlClkSrcBit] = use_core_q;
    ctrl_word[systick_pkg::CtrlSingleBit] = single_q;
    ctrl_word[systick_pkg::CtrlFlagBit]   = flag_q;
  end

  assign dec         = cur_q - COUNTER_WIDTH'(1);
  assign count_event = use_core_q || (presc_q == '1);

  always_comb begin
    run_d    = run_q;
    irq_en_d = irq_en_q;
    single_d = single_q;
    flag_d   = flag_q;
    reload_d = reload_q;
    cur_d    = cur_q;
    presc_d  = presc_q;
    res_o    = '0;
    if (fire_i) begin
      case (item_i.func)
        systick_pkg::FUNC_TICK: begin
          presc_d = presc_q + systick_pkg::PrescWidth'(1);
          if (count_event && run_q) begin
            if (cur_q == '0) begin
              cur_d = reload_q;
            end else begin
              cur_d = dec;
              if (dec == '0) begin
                res_o.reached_zero    = 1'b1;
                res_o.interrupt_pulse = irq_en_q;
                flag_d                = 1'b1;
                if (single_q) begin
                  run_d    = 1'b0;
                  reload_d = '0;
                  cur_d    = '0;
                end
              end
            end
          end
        end
        systick_pkg::FUNC_READ: begin
          case (item_i.reg_select)
            systick_pkg::SEL_CTRL: begin
              res_o.read_data = ctrl_word;
              flag_d          = 1'b0;
            end
            systick_pkg::SEL_RELOAD: begin
              res_o.read_data = systick_pkg::DataWidth'(reload_q);
            end
            systick_pkg::SEL_CURRENT: begin
              res_o.read_data = systick_pkg::DataWidth'(cur_q);
            end
            default: begin
              res_o.read_data = '0;
            end
          endcase
        end
        systick_pkg::FUNC_WRITE: begin
          case (item_i.reg_select)
            systick_pkg::SEL_CTRL: begin
              run_d    = item_i.write_data[systick_pkg::CtrlRunBit];
              irq_en_d = item_i.write_data[systick_pkg::CtrlIrqBit];
              single_d = item_i.write_data[systick_pkg::CtrlSingleBit];
            end
            systick_pkg::SEL_RELOAD: begin
              reload_d = item_i.write_data[COUNTER_WIDTH-1:0];
            end
            systick_pkg::SEL_CURRENT: begin
              cur_d  = '0;
              flag_d = 1'b0;
            end
            default: begin
              reload_d = reload_q;
            end
          endcase
        end
        default: begin
          presc_d = presc_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      use_core_q <= 1'b1;
      run_q      <= 1'b0;
      irq_en_q   <= 1'b0;
      single_q   <= 1'b0;
      flag_q     <= 1'b0;
      reload_q   <= '0;
      cur_q      <= '0;
      presc_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        use_core_q <= cfg_wdata_i;
      end
      run_q    <= run_d;
      irq_en_q <= irq_en_d;
      single_q <= single_d;
      flag_q   <= flag_d;
      reload_q <= reload_d;
      cur_q    <= cur_d;
      presc_q  <= presc_d;
    end
  end

  `SYSTICK_ASSERT(a_zero_clears_counter, fire_i && res_o.reached_zero |=> cur_q == '0, "counter not zero after reaching zero")
  `SYSTICK_ASSERT(a_zero_sets_flag, fire_i && res_o.reached_zero |=> flag_q, "count flag not set after reaching zero")
  `SYSTICK_ASSERT_ALWAYS(a_irq_needs_zero, res_o.interrupt_pulse |-> res_o.reached_zero && irq_en_q, "interrupt without zero crossing")
  `SYSTICK_ASSERT(a_single_shot_stops, fire_i && res_o.reached_zero && single_q |=> !run_q && reload_q == '0, "single-shot timer did not stop")

endmodule

>>> rtl/systick_out_reg.sv
// ----------------------------------------------------------------------------
// System tick down-timer result register
// Holds one result until the downstream side takes it.
// ----------------------------------------------------------------------------
module systick_out_reg (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 load_i,
  input  systick_pkg::result_t res_i,
  output logic                 ready_o,
  output logic                 m_valid_o,
  input  logic                 m_ready_i,
  output systick_pkg::result_t m_res_o
);

  logic                 valid_q, valid_d;
  systick_pkg::result_t res_q;

  assign ready_o = !valid_q || m_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (ready_o) begin
      valid_d = load_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i && ready_o) begin
      res_q <= res_i;
    end
  end

  assign m_valid_o = valid_q;
  assign m_res_o   = res_q;

endmodule

>>> rtl/system_tick_down_timer_top.sv
// ----------------------------------------------------------------------------
// System tick down-timer
// Reload down-counter with control, reload and current-value registers.
// ----------------------------------------------------------------------------
// Each slave transfer carries one request: tuser holds func (tick, read or
// write) and reg_select, tdata the write data. Each request produces exactly
// one master transfer with the read data in tdata and the interrupt pulse
// and zero-reached flags in tuser.
// A request is held in an input register and applied to the timer state
// when the result register can take it; the result is captured in the
// result register and offered from there as the master transfer.
// One request is accepted in every cycle while the receiver takes results;
// the counter state is updated between the input and result registers.
// When the receiver stalls, the result register holds its transfer and the
// input register takes one more request only if it was empty, then tready falls.
// Reset clears the valid state of both registers, stops the timer, clears
// all timer registers and selects the core clock. The clock-source bit is
// written through the configuration port; the user must write it only while
// no request is in flight, as the block itself does not enforce this.
module system_tick_down_timer_top #(
  parameter int unsigned COUNTER_WIDTH = 24
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // write_data
  input  logic [3:0]  s_axis_tuser,   // func[1:0], reg_select[3:2]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // read_data
  output logic [1:0]  m_axis_tuser    // interrupt_pulse[0], reached_zero[1]
);

  systick_pkg::item_t   s_item;
  systick_pkg::item_t   item;
  systick_pkg::result_t res;
  systick_pkg::result_t m_res;
  logic                 item_valid;
  logic                 out_ready;
  logic                 consume;

  assign s_item.func       = s_axis_tuser[1:0];
  assign s_item.reg_select = s_axis_tuser[3:2];
  assign s_item.write_data = s_axis_tdata;

  assign consume = item_valid && out_ready;

  systick_in_reg u_in_reg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .s_item_i  (s_item),
    .consume_i (consume),
    .valid_o   (item_valid),
    .item_o    (item)
  );

  systick_core #(
    .COUNTER_WIDTH (COUNTER_WIDTH)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .fire_i      (consume),
    .item_i      (item),
    .res_o       (res)
  );

  systick_out_reg u_out_reg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .load_i    (consume),
    .res_i     (res),
    .ready_o   (out_ready),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .m_res_o   (m_res)
  );

  assign m_axis_tdata    = m_res.read_data;
  assign m_axis_tuser[0] = m_res.interrupt_pulse;
  assign m_axis_tuser[1] = m_res.reached_zero;

endmodule
